// File: design/tlp_pkg.sv
// Shared types and constants of the tilt line parser.
// Used by every module of the block; depends on nothing else.
package tlp_pkg;

    // Character codes that steer the parser.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Number magnitude saturates at 2^31.
    localparam logic [31:0] MAG_CAP     = 32'h8000_0000;
    localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;

    // Configuration register map.
    localparam int unsigned CFG_ADDR_W        = 3;
    localparam logic        REG_TILT_DEADBAND = 1'b0;
    localparam logic [5:0]  DEADBAND_RESET    = 6'd3;

    // Paddle row and tilt constants.
    localparam int          TILT_LIMIT = 45;
    localparam logic [7:0]  ROW_MAX    = 8'd160;
    // 16/9 scaled by 2^16: floor(x*16/9) == (x*RECIP_16_9) >> 16 for x in 0..90.
    localparam logic [16:0] RECIP_16_9 = 17'd116512;

    // Line queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PHASE_SKIP   = 2'd0,
        PHASE_DIGITS = 2'd1,
        PHASE_DONE   = 2'd2
    } num_phase_t;

    // One finished line as handed from the front part to the back part.
    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] heading;
    } line_rec_t;

    // Queue status seen by the front part.
    typedef struct packed {
        logic push;
        logic full;
    } queue_ctrl_t;

endpackage

// File: design/tlp_rx_if.sv
// Input channel of the tilt line parser: valid/ready with one received byte.
// Stand-alone interface, no dependencies.
interface tlp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       line_error;

    modport source (output valid, output rx_byte, output line_error, input ready);
    modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

// File: design/tlp_result_if.sv
// Result channel of the tilt line parser: valid/ready with one parsed line.
// Stand-alone interface, no dependencies.
interface tlp_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle;
    logic signed [31:0] heading;
    logic [7:0]         paddle_row;
    logic [1:0]         tilt_class;
    logic [2:0]         compass_sector;

    modport source (output valid, output angle, output heading, output paddle_row,
                    output tilt_class, output compass_sector, input ready);
    modport sink   (input valid, input angle, input heading, input paddle_row,
                    input tilt_class, input compass_sector, output ready);
endinterface

// File: design/tlp_front.sv
// Front part: parses received bytes on the fly and emits one record per line.
// Depends on tlp_pkg.
module tlp_front #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  logic                 line_error,
    input  logic                 queue_full,
    output tlp_pkg::queue_ctrl_t qctl,
    output tlp_pkg::line_rec_t   rec
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_CAPACITY - 1);

    logic [CNT_W-1:0]    char_count_reg, char_count_next;
    logic [1:0]          field_number_reg, field_number_next;
    tlp_pkg::num_phase_t number_phase_reg, number_phase_next;
    logic                negative_sign_reg, negative_sign_next;
    logic [31:0]         digit_accum_reg, digit_accum_next;
    logic [31:0]         held_angle_reg, held_angle_next;
    logic                string_ended_reg, string_ended_next;

    logic [31:0] number_value;
    logic        is_digit;
    logic        is_space;
    logic        is_eol;
    logic [34:0] acc_wide;
    logic [31:0] acc_sat;
    logic        push;

    always_comb
    begin
        if (negative_sign_reg)
            number_value = 32'd0 - digit_accum_reg;
        else if (digit_accum_reg > tlp_pkg::POS_MAX)
            number_value = tlp_pkg::POS_MAX;
        else
            number_value = digit_accum_reg;
    end

    assign is_digit = (rx_byte >= tlp_pkg::CHAR_ZERO) && (rx_byte <= tlp_pkg::CHAR_NINE);
    assign is_space = (rx_byte == tlp_pkg::CHAR_SPACE) || (rx_byte == tlp_pkg::CHAR_TAB) ||
                      (rx_byte == tlp_pkg::CHAR_VT) || (rx_byte == tlp_pkg::CHAR_FF);
    assign is_eol   = (rx_byte == tlp_pkg::CHAR_LF) || (rx_byte == tlp_pkg::CHAR_CR);

    // Ten times the magnitude plus the new digit, saturated at 2^31.
    assign acc_wide = {digit_accum_reg, 3'b000} + {2'b00, digit_accum_reg, 1'b0}
                    + {31'd0, rx_byte[3:0]};
    assign acc_sat  = (acc_wide > {3'b000, tlp_pkg::MAG_CAP}) ? tlp_pkg::MAG_CAP
                                                              : acc_wide[31:0];

    always_comb
    begin
        char_count_next    = char_count_reg;
        field_number_next  = field_number_reg;
        number_phase_next  = number_phase_reg;
        negative_sign_next = negative_sign_reg;
        digit_accum_next   = digit_accum_reg;
        held_angle_next    = held_angle_reg;
        string_ended_next  = string_ended_reg;
        push               = 1'b0;

        if (accept) begin
            if (line_error || (is_eol && (char_count_reg != '0))) begin
                push               = !line_error;
                char_count_next    = '0;
                field_number_next  = 2'd0;
                number_phase_next  = tlp_pkg::PHASE_SKIP;
                negative_sign_next = 1'b0;
                digit_accum_next   = '0;
                held_angle_next    = '0;
                string_ended_next  = 1'b0;
            end
            else if (!is_eol && (char_count_reg < CNT_LIMIT)) begin
                char_count_next = char_count_reg + 1'b1;
                if (!string_ended_reg) begin
                    if (rx_byte == tlp_pkg::CHAR_NUL) begin
                        string_ended_next = 1'b1;
                    end
                    else if ((rx_byte == tlp_pkg::CHAR_COMMA) && (field_number_reg < 2'd2)) begin
                        if (field_number_reg == 2'd0)
                            held_angle_next = number_value;
                        field_number_next  = field_number_reg + 1'b1;
                        number_phase_next  = tlp_pkg::PHASE_SKIP;
                        negative_sign_next = 1'b0;
                        digit_accum_next   = '0;
                    end
                    else if (field_number_reg != 2'd1) begin
                        case (number_phase_reg)
                            tlp_pkg::PHASE_SKIP:
                            begin
                                if (rx_byte == tlp_pkg::CHAR_MINUS || rx_byte == tlp_pkg::CHAR_PLUS) begin
                                    negative_sign_next = (rx_byte == tlp_pkg::CHAR_MINUS);
                                    number_phase_next  = tlp_pkg::PHASE_DIGITS;
                                end
                                else if (is_digit) begin
                                    number_phase_next = tlp_pkg::PHASE_DIGITS;
                                    digit_accum_next  = acc_sat;
                                end
                                else if (!is_space) begin
                                    number_phase_next = tlp_pkg::PHASE_DONE;
                                end
                            end
                            tlp_pkg::PHASE_DIGITS:
                            begin
                                if (is_digit)
                                    digit_accum_next = acc_sat;
                                else
                                    number_phase_next = tlp_pkg::PHASE_DONE;
                            end
                            default:
                            begin
                                number_phase_next = number_phase_reg;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_count_reg    <= '0;
            field_number_reg  <= 2'd0;
            number_phase_reg  <= tlp_pkg::PHASE_SKIP;
            negative_sign_reg <= 1'b0;
            digit_accum_reg   <= '0;
            held_angle_reg    <= '0;
            string_ended_reg  <= 1'b0;
        end
        else begin
            char_count_reg    <= char_count_next;
            field_number_reg  <= field_number_next;
            number_phase_reg  <= number_phase_next;
            negative_sign_reg <= negative_sign_next;
            digit_accum_reg   <= digit_accum_next;
            held_angle_reg    <= held_angle_next;
            string_ended_reg  <= string_ended_next;
        end
    end

    // The record is only pushed when the queue has room; the top level holds
    // ready low while it is full.
    assign qctl.push    = push && !queue_full;
    assign qctl.full    = queue_full;
    assign rec.angle    = (field_number_reg >= 2'd1) ? held_angle_reg : 32'd0;
    assign rec.heading  = (field_number_reg == 2'd2) ? number_value : 32'd0;

endmodule

// File: design/tlp_queue.sv
// Short register queue carrying finished line records to the back part.
// Depends on tlp_pkg.
module tlp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlp_pkg::queue_ctrl_t qctl,
    input  tlp_pkg::line_rec_t   wr_rec,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output tlp_pkg::line_rec_t   rd_rec
);

    tlp_pkg::line_rec_t                 slot_reg [tlp_pkg::QUEUE_DEPTH];
    logic [tlp_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [tlp_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [tlp_pkg::QCNT_W-1:0]         count_reg, count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full      = (count_reg == tlp_pkg::QCNT_W'(tlp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = qctl.push && !qctl.full;
    assign do_pop    = pop && not_empty;
    assign rd_rec    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_rec;
    end

endmodule

// File: design/tlp_back.sv
// Back part: turns a line record into paddle row, tilt class and compass sector,
// and holds the result in an output register. Depends on tlp_pkg and tlp_result_if.
module tlp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    input  tlp_pkg::line_rec_t rec,
    input  logic [5:0]         deadband,
    output logic               pop,
    tlp_result_if.source       result
);

    logic signed [31:0] ang;
    logic signed [31:0] head;
    logic signed [31:0] dead_pos;
    logic signed [31:0] dead_neg;
    logic [6:0]         clamp_idx;
    logic [23:0]        row_prod;
    logic [7:0]         row;
    logic [1:0]         tilt;
    logic [2:0]         sector;

    logic               valid_reg, valid_next;
    logic signed [31:0] angle_reg;
    logic signed [31:0] heading_reg;
    logic [7:0]         row_reg;
    logic [1:0]         tilt_reg;
    logic [2:0]         sector_reg;

    assign ang      = $signed(rec.angle);
    assign head     = $signed(rec.heading);
    assign dead_pos = $signed({26'd0, deadband});
    assign dead_neg = 32'sd0 - dead_pos;

    always_comb
    begin
        if (ang > 32'sd45)
            clamp_idx = 7'd90;
        else if (ang < -32'sd45)
            clamp_idx = 7'd0;
        else
            clamp_idx = ang[6:0] + 7'd45;
    end

    assign row_prod = {17'd0, clamp_idx} * {7'd0, tlp_pkg::RECIP_16_9};
    assign row      = tlp_pkg::ROW_MAX - row_prod[23:16];

    always_comb
    begin
        if (ang > dead_pos)
            tilt = 2'd1;
        else if (ang < dead_neg)
            tilt = 2'd2;
        else
            tilt = 2'd0;
    end

    // Sectors are 45 degrees wide, starting at 23; north wraps round both ends.
    always_comb
    begin
        if (head < 32'sd23 || head >= 32'sd338)
            sector = 3'd0;
        else if (head < 32'sd68)
            sector = 3'd1;
        else if (head < 32'sd113)
            sector = 3'd2;
        else if (head < 32'sd158)
            sector = 3'd3;
        else if (head < 32'sd203)
            sector = 3'd4;
        else if (head < 32'sd248)
            sector = 3'd5;
        else if (head < 32'sd293)
            sector = 3'd6;
        else
            sector = 3'd7;
    end

    assign pop = rec_valid && (!valid_reg || result.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            angle_reg   <= ang;
            heading_reg <= head;
            row_reg     <= row;
            tilt_reg    <= tilt;
            sector_reg  <= sector;
        end
    end

    assign result.valid          = valid_reg;
    assign result.angle          = angle_reg;
    assign result.heading        = heading_reg;
    assign result.paddle_row     = row_reg;
    assign result.tilt_class     = tilt_reg;
    assign result.compass_sector = sector_reg;

endmodule

// File: design/tilt_line_parser.sv
// Top level of the tilt line parser: configuration register, front parser,
// line queue and back result stage. Depends on tlp_pkg, tlp_rx_if, tlp_result_if,
// tlp_front, tlp_queue and tlp_back.
//
// Usage
// The rx channel carries one received character per transaction, together with a
// line error flag. A line error throws away the partial line and the character.
// A CR or LF that ends a non-empty line produces one transaction on the result
// channel, carrying the angle, the heading, the paddle row, the tilt class and the
// compass sector. All other characters produce no result.
// Throughput is one character per clock cycle while the line queue is not full.
// The result of a line is registered first into the line queue on the transaction
// of its terminating character, then through the back stage into the output
// register, once that register is free or being read.
// When the result receiver stalls, finished lines collect in a four-entry queue
// and the parser keeps taking characters; rx.ready only drops once the queue is
// full. Reset clears all line state, empties the queue and the output register
// and sets the tilt dead band to 3. The dead band is written through the APB
// port at addresses 0 to 3.
module tilt_line_parser #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tlp_rx_if.sink                          rx,
    tlp_result_if.source                    result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [5:0]           deadband_reg, deadband_next;
    logic                 cfg_write;
    logic                 rx_accept;
    logic                 queue_full;
    logic                 queue_not_empty;
    logic                 queue_pop;
    tlp_pkg::queue_ctrl_t qctl;
    tlp_pkg::line_rec_t   front_rec;
    tlp_pkg::line_rec_t   back_rec;

    // Configuration port: always ready, one register in the low word.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[tlp_pkg::CFG_ADDR_W-1] == tlp_pkg::REG_TILT_DEADBAND);
    assign deadband_next = cfg_write ? pwdata[5:0] : deadband_reg;
    assign prdata = (paddr[tlp_pkg::CFG_ADDR_W-1] == tlp_pkg::REG_TILT_DEADBAND)
                  ? {26'd0, deadband_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deadband_reg <= tlp_pkg::DEADBAND_RESET;
        else
            deadband_reg <= deadband_next;
    end

    // A character is taken whenever the queue can hold a possible line record.
    assign rx.ready  = !queue_full;
    assign rx_accept = rx.valid && rx.ready;

    tlp_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (rx_accept),
        .rx_byte    (rx.rx_byte),
        .line_error (rx.line_error),
        .queue_full (queue_full),
        .qctl       (qctl),
        .rec        (front_rec)
    );

    tlp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .qctl      (qctl),
        .wr_rec    (front_rec),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .rd_rec    (back_rec)
    );

    tlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (queue_not_empty),
        .rec       (back_rec),
        .deadband  (deadband_reg),
        .pop       (queue_pop),
        .result    (result)
    );

endmodule
